// ===== rtl/outstanding_request_tracker_defines.svh =====
// assertion macros for the outstanding request tracker
`ifndef OUTSTANDING_REQUEST_TRACKER_DEFINES_SVH
`define OUTSTANDING_REQUEST_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while arst_n is low
`define ORT_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, sampled on clk, off while arst_n is low
`define ORT_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ORT_ASSERT_IMP(name, ante, cons, msg)
`define ORT_ASSERT_NXT(name, ante, cons, msg)
`endif

`endif

// ===== rtl/ort_pkg.sv =====
// shared types and constants of the outstanding request tracker
package ort_pkg;

	localparam int SLOTS_DEF = 64;
	localparam int SEQ_W     = 64;
	localparam int TS_W      = 64;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 32;

	typedef logic [1:0] op_t;
	localparam op_t OP_ISSUE = 2'd0;
	localparam op_t OP_CPL   = 2'd1;
	localparam op_t OP_RESET = 2'd2;
	localparam op_t OP_NOP   = 2'd3;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_BAD_MAGIC = 3'd1;
	localparam status_t ST_BAD_CORE  = 3'd2;
	localparam status_t ST_BAD_SLOT  = 3'd3;
	localparam status_t ST_BAD_SEQ   = 3'd4;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_OWN_CORE = 1'd0;
	localparam cfg_idx_t CFG_MAGIC    = 1'd1;

	// write side of the slot memories
	typedef struct packed {
		logic             seq_we;
		logic             ts_we;
		logic [SEQ_W-1:0] seq;
		logic [TS_W-1:0]  ts;
	} slot_wr_t;

endpackage

// ===== rtl/ort_prio_enc.sv =====
// lowest-set-bit priority encoder
module ort_prio_enc #(
	parameter int N     = ort_pkg::SLOTS_DEF,
	parameter int IDX_W = $clog2(ort_pkg::SLOTS_DEF)
) (
	input  logic [N-1:0]     vec,
	output logic             found,
	output logic [IDX_W-1:0] idx
);
	import ort_pkg::*;

	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (vec[i]) begin
				found = 1'b1;
				idx   = IDX_W'(i);
			end
		end
	end

endmodule

// ===== rtl/ort_slot_mem.sv =====
// per-slot sequence and timestamp memories, registered read
module ort_slot_mem #(
	parameter int SLOTS = ort_pkg::SLOTS_DEF,
	parameter int IDX_W = $clog2(ort_pkg::SLOTS_DEF)
) (
	input  logic                    clk,
	input  logic                    rd_en,
	input  logic [IDX_W-1:0]        rd_addr,
	output logic [ort_pkg::SEQ_W-1:0] seq_rd,
	output logic [ort_pkg::TS_W-1:0]  ts_rd,
	input  logic [IDX_W-1:0]        wr_addr,
	input  ort_pkg::slot_wr_t       wr
);
	import ort_pkg::*;

	logic [SEQ_W-1:0] seq_mem [SLOTS];
	logic [TS_W-1:0]  ts_mem  [SLOTS];

	always_ff @(posedge clk) begin
		if (wr.seq_we) begin
			seq_mem[wr_addr] <= wr.seq;
		end
		if (rd_en) begin
			seq_rd <= seq_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.ts_we) begin
			ts_mem[wr_addr] <= wr.ts;
		end
		if (rd_en) begin
			ts_rd <= ts_mem[rd_addr];
		end
	end

endmodule

// ===== rtl/outstanding_request_tracker.sv =====
// outstanding request tracker top level
//
// command channel: an item is taken on a rising edge with start high and busy low.
// operation selects issue, completion, channel reset (mark all live slots for
// resend) or no-op; now, cpl_magic, cpl_core, cpl_slot and cpl_seq ride along.
// every item gives exactly one result beat, done high for one cycle from the result
// registers behind stages 1 and 2. the receiver cannot hold results off.
// busy is high for one cycle after each accept, so no new item is taken while one
// is in stage 1: the slot memories are read on the accept edge and written back
// on the next edge, and the next item must see that write. the lowest free or
// lowest marked slot comes from a priority encoder over flop-based bit vectors.
// latency totals are added in the stage after the table update, overlapping the
// next item's table access.
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready;
// index 0 is the owned core id, index 1 the expected magic word. write it only
// while no item is in flight.
// reset: all slots free, no resend marks, resend mode off, next sequence 1,
// totals and registers zero. no clearing pass is needed; timestamps are never
// read before they are written.
`include "outstanding_request_tracker_defines.svh"

module outstanding_request_tracker #(
	parameter int SLOTS = ort_pkg::SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// command channel
	input  logic                         start,
	output logic                         busy,
	input  ort_pkg::op_t                 operation,
	input  logic [63:0]                  now,
	input  logic [31:0]                  cpl_magic,
	input  logic [15:0]                  cpl_core,
	input  logic [15:0]                  cpl_slot,
	input  logic [63:0]                  cpl_seq,
	// config channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ort_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ort_pkg::CFG_DAT_W-1:0] cfg_data,
	// result beat
	output logic                         done,
	output logic                         granted,
	output logic                         is_resend,
	output logic [5:0]                   slot_index,
	output logic [63:0]                  request_seq,
	output ort_pkg::status_t             status,
	output logic [63:0]                  latency,
	output logic [63:0]                  total_latency_out,
	output logic [63:0]                  completions_out
);
	import ort_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);

	// configuration registers
	logic [15:0] own_core_q;
	logic [31:0] magic_q;

	// slot bookkeeping in flops: occupancy stands in for a nonzero sequence
	logic [SLOTS-1:0] occupied_q;
	logic [SLOTS-1:0] mark_q;
	logic             resend_mode_q;
	logic [SEQ_W-1:0] next_seq_q;

	logic accept;

	// lowest free and lowest marked slot
	logic             free_found;
	logic [IDX_W-1:0] free_idx;
	logic             mark_found;
	logic [IDX_W-1:0] mark_idx;

	logic [IDX_W-1:0] rd_addr;
	logic             found_d;

	// stage 1: memory read in flight, decide and write back
	logic             valid_s1;
	op_t              op_s1;
	logic [TS_W-1:0]  now_s1;
	logic [SEQ_W-1:0] seq_s1;
	logic             magic_ok_s1;
	logic             core_ok_s1;
	logic             range_ok_s1;
	logic             found_s1;
	logic [IDX_W-1:0] addr_s1;

	logic [SEQ_W-1:0] seq_rd;
	logic [TS_W-1:0]  ts_rd;
	slot_wr_t         mem_wr;

	// stage 1 decisions
	logic             grant_c;
	logic             resend_c;
	logic             take_c;
	logic             cpl_ok_c;
	logic             set_mode_c;
	logic             clr_mode_c;
	status_t          status_c;
	logic [SEQ_W-1:0] rseq_c;
	logic [TS_W-1:0]  lat_c;
	logic [SEQ_W-1:0] seq_inc;

	// stage 2: totals update
	logic             valid_s2;
	logic             granted_s2;
	logic             resend_s2;
	logic [5:0]       idx_s2;
	logic [SEQ_W-1:0] rseq_s2;
	status_t          status_s2;
	logic [TS_W-1:0]  lat_s2;
	logic             ok_s2;

	// result registers
	logic             done_q;
	logic             granted_q;
	logic             resend_q;
	logic [5:0]       idx_q;
	logic [SEQ_W-1:0] rseq_q;
	status_t          status_q;
	logic [TS_W-1:0]  lat_q;
	logic [63:0]      lat_sum_q;
	logic [63:0]      cpl_cnt_q;

	assign accept    = start & ~busy;
	assign busy      = valid_s1;
	assign cfg_ready = 1'b1;

	// config writes, taken any time the port handshakes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_core_q <= '0;
			magic_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_OWN_CORE: own_core_q <= cfg_data[15:0];
				CFG_MAGIC:    magic_q    <= cfg_data;
			endcase
		end
	end

	ort_prio_enc #(.N(SLOTS), .IDX_W(IDX_W)) u_free_enc (
		.vec   (~occupied_q),
		.found (free_found),
		.idx   (free_idx)
	);

	ort_prio_enc #(.N(SLOTS), .IDX_W(IDX_W)) u_mark_enc (
		.vec   (mark_q),
		.found (mark_found),
		.idx   (mark_idx)
	);

	// read address picked on the accept edge: completion slot, or the slot
	// an issue would take (marked one in resend mode, else lowest free)
	always_comb begin
		if (operation == OP_CPL) begin
			rd_addr = cpl_slot[IDX_W-1:0];
		end else if (resend_mode_q) begin
			rd_addr = mark_idx;
		end else begin
			rd_addr = free_idx;
		end
		found_d = resend_mode_q ? mark_found : free_found;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// command beat capture; the early checks are done here to shorten stage 1
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= operation;
			now_s1      <= now;
			seq_s1      <= cpl_seq;
			magic_ok_s1 <= (cpl_magic == magic_q);
			core_ok_s1  <= (cpl_core == own_core_q);
			range_ok_s1 <= (cpl_slot < 16'(SLOTS));
			found_s1    <= found_d;
			addr_s1     <= rd_addr;
		end
	end

	ort_slot_mem #(.SLOTS(SLOTS), .IDX_W(IDX_W)) u_slot_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.seq_rd  (seq_rd),
		.ts_rd   (ts_rd),
		.wr_addr (addr_s1),
		.wr      (mem_wr)
	);

	// next sequence number skips zero, which marks a free slot
	assign seq_inc = (next_seq_q + 64'd1 == '0) ? 64'd1 : next_seq_q + 64'd1;

	always_comb begin
		grant_c    = 1'b0;
		resend_c   = 1'b0;
		take_c     = 1'b0;
		cpl_ok_c   = 1'b0;
		set_mode_c = 1'b0;
		clr_mode_c = 1'b0;
		status_c   = ST_OK;
		rseq_c     = '0;
		lat_c      = '0;
		unique case (op_s1)
			OP_ISSUE: begin
				if (resend_mode_q) begin
					if (found_s1) begin
						grant_c  = 1'b1;
						resend_c = 1'b1;
						rseq_c   = seq_rd;
					end else begin
						clr_mode_c = 1'b1;
					end
				end else if (found_s1) begin
					grant_c = 1'b1;
					take_c  = 1'b1;
					rseq_c  = next_seq_q;
				end
			end
			OP_CPL: begin
				priority if (!magic_ok_s1) begin
					status_c = ST_BAD_MAGIC;
				end else if (!core_ok_s1) begin
					status_c = ST_BAD_CORE;
				end else if (!range_ok_s1) begin
					status_c = ST_BAD_SLOT;
				end else if (!occupied_q[addr_s1] || seq_rd != seq_s1) begin
					// a free slot never matches, whatever the sequence
					status_c = ST_BAD_SEQ;
				end else begin
					cpl_ok_c = 1'b1;
					lat_c    = now_s1 - ts_rd;
				end
			end
			OP_RESET: begin
				set_mode_c = 1'b1;
			end
			OP_NOP: begin
			end
		endcase
	end

	// write back: new issue stamps sequence and time, resend only the time
	always_comb begin
		mem_wr.seq_we = valid_s1 & take_c;
		mem_wr.ts_we  = valid_s1 & grant_c;
		mem_wr.seq    = next_seq_q;
		mem_wr.ts     = now_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupied_q    <= '0;
			mark_q        <= '0;
			resend_mode_q <= 1'b0;
			next_seq_q    <= 64'd1;
		end else if (valid_s1) begin
			if (take_c) begin
				occupied_q[addr_s1] <= 1'b1;
				next_seq_q          <= seq_inc;
			end
			if (cpl_ok_c) begin
				occupied_q[addr_s1] <= 1'b0;
			end
			if (grant_c || cpl_ok_c) begin
				mark_q[addr_s1] <= 1'b0;
			end
			if (set_mode_c) begin
				mark_q        <= mark_q | occupied_q;
				resend_mode_q <= 1'b1;
			end
			if (clr_mode_c) begin
				resend_mode_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			granted_s2 <= grant_c;
			resend_s2  <= resend_c;
			idx_s2     <= grant_c ? 6'(addr_s1) : 6'd0;
			rseq_s2    <= rseq_c;
			status_s2  <= status_c;
			lat_s2     <= lat_c;
			ok_s2      <= cpl_ok_c;
		end
	end

	// totals and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= 1'b0;
			lat_sum_q <= '0;
			cpl_cnt_q <= '0;
		end else begin
			done_q <= valid_s2;
			if (valid_s2) begin
				lat_sum_q <= lat_sum_q + lat_s2;
				cpl_cnt_q <= cpl_cnt_q + 64'(ok_s2);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			granted_q <= granted_s2;
			resend_q  <= resend_s2;
			idx_q     <= idx_s2;
			rseq_q    <= rseq_s2;
			status_q  <= status_s2;
			lat_q     <= lat_s2;
		end
	end

	assign done              = done_q;
	assign granted           = granted_q;
	assign is_resend         = resend_q;
	assign slot_index        = idx_q;
	assign request_seq       = rseq_q;
	assign status            = status_q;
	assign latency           = lat_q;
	assign total_latency_out = lat_sum_q;
	assign completions_out   = cpl_cnt_q;

	// one item in flight at a time: busy lasts a single cycle
	`ORT_ASSERT_NXT(a_busy_one_cycle, busy, !busy, "busy held for more than one cycle")
	// a grant never carries an error status, and a resend is always a grant
	`ORT_ASSERT_IMP(a_grant_no_error, done && granted, status == ST_OK, "grant with error status")
	`ORT_ASSERT_IMP(a_resend_granted, done && is_resend, granted, "resend without grant")
	// sequence zero is reserved for free slots
	`ORT_ASSERT_IMP(a_seq_nonzero, done && granted && !is_resend, request_seq != '0,
		"new request got sequence zero")
	`ORT_ASSERT_IMP(a_next_seq_nonzero, 1'b1, next_seq_q != '0, "next sequence reached zero")

endmodule

// ===== sim/outstanding_request_tracker_tb.sv =====
// self-checking testbench for the outstanding request tracker: directed and random beats
`timescale 1ns / 100ps

module outstanding_request_tracker_tb;
	import ort_pkg::*;

	localparam int SLOT_COUNT       = SLOTS_DEF;
	localparam int WATCHDOG_LIMIT   = 4000;
	// cycles of silence before a register write, so no item is still in the result pipeline
	localparam int QUIET_NEEDED     = 4;
	localparam int RANDOM_PER_PHASE = 100;
	localparam int PHASES           = 4;

	// what a completion beat aims at; issue, reset and no-op beats ignore it
	typedef enum int {
		CK_MATCH,
		CK_WRONG_SEQ,
		CK_FREE_SLOT,
		CK_OUT_RANGE,
		CK_BAD_MAGIC,
		CK_BAD_CORE
	} cpl_kind_t;

	// one entry of the command backlog: either a register write or a command beat
	typedef struct {
		bit          is_cfg;
		cfg_idx_t    cfg_idx;
		logic [31:0] cfg_val;
		op_t         op;
		cpl_kind_t   kind;
		logic [63:0] stamp;
		logic [31:0] rnd_magic;
		logic [15:0] rnd_core;
		logic [15:0] rnd_slot;
		logic [63:0] rnd_seq;
		int          idle_pct;
		bit          wait_empty;
	} cmd_t;

	typedef struct {
		logic        granted;
		logic        is_resend;
		logic [5:0]  slot_index;
		logic [63:0] request_seq;
		status_t     status;
		logic [63:0] latency;
		logic [63:0] total;
		logic [63:0] count;
	} tracker_result_t;

	// ports; the inputs are all known from time zero
	logic        clk               = 1'b0;
	logic        arst_n            = 1'b0;
	logic        start             = 1'b0;
	logic        busy;
	op_t         operation         = OP_NOP;
	logic [63:0] now               = '0;
	logic [31:0] cpl_magic         = '0;
	logic [15:0] cpl_core          = '0;
	logic [15:0] cpl_slot          = '0;
	logic [63:0] cpl_seq           = '0;
	logic        cfg_valid         = 1'b0;
	logic        cfg_ready;
	cfg_idx_t    cfg_index         = CFG_OWN_CORE;
	logic [CFG_DAT_W-1:0] cfg_data = '0;
	logic        done;
	logic        granted;
	logic        is_resend;
	logic [5:0]  slot_index;
	logic [63:0] request_seq;
	status_t     status;
	logic [63:0] latency;
	logic [63:0] total_latency_out;
	logic [63:0] completions_out;

	outstanding_request_tracker DUT (.*);

	// shadow copy of the tracker state, advanced on every accepted beat
	logic [63:0]           shadow_seq [SLOT_COUNT];
	logic [63:0]           shadow_ts  [SLOT_COUNT];
	bit [SLOT_COUNT-1:0]   shadow_mark;
	// slots whose timestamp was ever written, the only in-range ones a completion may name
	bit [SLOT_COUNT-1:0]   shadow_written;
	logic [63:0]           shadow_next_seq = 64'd1;
	bit                    shadow_resend;
	logic [63:0]           shadow_lat_sum  = '0;
	logic [63:0]           shadow_cpl_cnt  = '0;
	logic [15:0]           shadow_core     = '0;
	logic [31:0]           shadow_magic    = '0;

	cmd_t            cmd_backlog [$];
	tracker_result_t due_results [$];

	int          mismatches   = 0;
	int          items_queued = 0;
	int          quiet_cycles = 0;
	int          idle_edges   = 0;
	logic [63:0] timer        = '0;
	bit          took_item;
	bit          holding;
	cmd_t        next_cmd;
	logic [31:0] shaped_magic;
	logic [15:0] shaped_core;
	logic [15:0] shaped_slot;
	logic [63:0] shaped_seq;
	tracker_result_t want;

	initial begin
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// predictor: one accepted command beat in, the result beat it causes out
	// ------------------------------------------------------------------
	function automatic tracker_result_t track_item(input op_t op, input logic [63:0] t,
		input logic [31:0] m, input logic [15:0] c, input logic [15:0] s,
		input logic [63:0] q);
		tracker_result_t r;
		int pick;
		int i;
		r.granted     = 1'b0;
		r.is_resend   = 1'b0;
		r.slot_index  = '0;
		r.request_seq = '0;
		r.status      = ST_OK;
		r.latency     = '0;
		pick = -1;
		case (op)
		OP_ISSUE: begin
			if (shadow_resend) begin
				// lowest marked slot goes out again with its old sequence number
				for (i = SLOT_COUNT - 1; i >= 0; i--)
					if (shadow_mark[i])
						pick = i;
				if (pick >= 0) begin
					shadow_ts[pick]   = t;
					shadow_mark[pick] = 1'b0;
					r.granted         = 1'b1;
					r.is_resend       = 1'b1;
					r.slot_index      = 6'(pick);
					r.request_seq     = shadow_seq[pick];
				end else begin
					// nothing left to resend: leave resend mode, grant nothing
					shadow_resend = 1'b0;
				end
			end else begin
				for (i = SLOT_COUNT - 1; i >= 0; i--)
					if (shadow_seq[i] == 64'd0)
						pick = i;
				if (pick >= 0) begin
					r.request_seq   = shadow_next_seq;
					// zero marks a free slot, so the counter skips it on wrap
					shadow_next_seq = shadow_next_seq + 64'd1;
					if (shadow_next_seq == 64'd0)
						shadow_next_seq = 64'd1;
					shadow_seq[pick]     = r.request_seq;
					shadow_ts[pick]      = t;
					shadow_mark[pick]    = 1'b0;
					shadow_written[pick] = 1'b1;
					r.granted            = 1'b1;
					r.slot_index         = 6'(pick);
				end
			end
		end
		OP_CPL: begin
			// checks in priority order: magic, core, slot range, sequence
			if (m != shadow_magic)
				r.status = ST_BAD_MAGIC;
			else if (c != shadow_core)
				r.status = ST_BAD_CORE;
			else if (s >= SLOT_COUNT)
				r.status = ST_BAD_SLOT;
			else if (shadow_seq[s[5:0]] == 64'd0 || shadow_seq[s[5:0]] != q)
				r.status = ST_BAD_SEQ;
			else begin
				r.latency                = t - shadow_ts[s[5:0]];
				shadow_lat_sum           = shadow_lat_sum + r.latency;
				shadow_cpl_cnt           = shadow_cpl_cnt + 64'd1;
				shadow_seq[s[5:0]]       = 64'd0;
				shadow_mark[s[5:0]]      = 1'b0;
			end
		end
		OP_RESET: begin
			shadow_resend = 1'b1;
			for (i = 0; i < SLOT_COUNT; i++)
				if (shadow_seq[i] != 64'd0)
					shadow_mark[i] = 1'b1;
		end
		default: ;
		endcase
		r.total = shadow_lat_sum;
		r.count = shadow_cpl_cnt;
		return r;
	endfunction

	// turn a completion's aim into concrete fields from the current shadow state;
	// a slot inside the table range is only named once its timestamp has been written
	function automatic void shape_completion(input cmd_t p, output logic [31:0] m,
		output logic [15:0] c, output logic [15:0] s, output logic [63:0] q);
		int live[$];
		int idle_slots[$];
		int i;
		m = p.rnd_magic;
		c = p.rnd_core;
		s = p.rnd_slot;
		q = p.rnd_seq;
		if (p.op != OP_CPL)
			return;
		for (i = 0; i < SLOT_COUNT; i++) begin
			if (shadow_seq[i] != 64'd0)
				live.push_back(i);
			else if (shadow_written[i])
				idle_slots.push_back(i);
		end
		m = shadow_magic;
		c = shadow_core;
		case (p.kind)
		CK_MATCH, CK_WRONG_SEQ, CK_BAD_MAGIC, CK_BAD_CORE: begin
			if (live.size() > 0) begin
				s = 16'(live[$urandom_range(live.size() - 1)]);
				q = shadow_seq[s[5:0]];
				if (p.kind == CK_WRONG_SEQ)
					q = q ^ ((p.rnd_seq == 64'd0) ? 64'd1 : p.rnd_seq);
			end else if (idle_slots.size() > 0) begin
				s = 16'(idle_slots[$urandom_range(idle_slots.size() - 1)]);
			end
		end
		CK_FREE_SLOT: begin
			if (idle_slots.size() > 0)
				s = 16'(idle_slots[$urandom_range(idle_slots.size() - 1)]);
		end
		default: ;
		endcase
		if (p.kind == CK_BAD_MAGIC) begin
			m = shadow_magic ^ ((p.rnd_magic == 32'd0) ? 32'd1 : p.rnd_magic);
			// sometimes a wrong core too, magic must still win
			if (p.rnd_seq[0])
				c = p.rnd_core;
		end
		if (p.kind == CK_BAD_CORE) begin
			c = shadow_core ^ ((p.rnd_core == 16'd0) ? 16'd1 : p.rnd_core);
			// sometimes a bad slot too, core must still win
			if (p.rnd_seq[1])
				s = p.rnd_slot;
		end
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic [63:0] next_stamp();
		// mostly a rising timer, now and then an arbitrary value so latencies wrap
		if ($urandom_range(15) == 0)
			return {$urandom, $urandom};
		timer = timer + 64'($urandom_range(1000, 1));
		return timer;
	endfunction

	function automatic cmd_t make_item(input op_t op, input cpl_kind_t kind, input int idle);
		cmd_t e;
		e.is_cfg     = 1'b0;
		e.cfg_idx    = CFG_OWN_CORE;
		e.cfg_val    = '0;
		e.op         = op;
		e.kind       = kind;
		e.stamp      = next_stamp();
		e.rnd_magic  = $urandom;
		e.rnd_core   = 16'($urandom);
		// always out of range unless shaping picks a real slot
		e.rnd_slot   = 16'($urandom_range(65535, SLOT_COUNT));
		e.rnd_seq    = {$urandom, $urandom};
		e.idle_pct   = idle;
		e.wait_empty = ($urandom_range(39) == 0);
		return e;
	endfunction

	function automatic cmd_t make_cfg(input cfg_idx_t idx, input logic [31:0] val);
		cmd_t e;
		e            = make_item(OP_NOP, CK_MATCH, 0);
		e.is_cfg     = 1'b1;
		e.cfg_idx    = idx;
		e.cfg_val    = val;
		return e;
	endfunction

	function automatic cpl_kind_t pick_kind();
		int r;
		r = $urandom_range(99);
		if (r < 50) return CK_MATCH;
		if (r < 62) return CK_WRONG_SEQ;
		if (r < 74) return CK_FREE_SLOT;
		if (r < 82) return CK_OUT_RANGE;
		if (r < 91) return CK_BAD_MAGIC;
		return CK_BAD_CORE;
	endfunction

	function automatic op_t pick_op();
		int r;
		r = $urandom_range(99);
		if (r < 40) return OP_ISSUE;
		if (r < 85) return OP_CPL;
		if (r < 93) return OP_RESET;
		return OP_NOP;
	endfunction

	task automatic push_cmd(input cmd_t e);
		cmd_backlog.push_back(e);
		items_queued++;
	endtask

	// one random episode: a well-formed sequence with random content, or plain noise
	task automatic add_episode(input int idle);
		int n;
		int i;
		op_t op;
		case ($urandom_range(3))
		0: begin
			// fill the table, often to the point where issues are refused
			n = $urandom_range(70, 40);
			for (i = 0; i < n; i++) begin
				if ($urandom_range(9) == 0)
					push_cmd(make_item(OP_CPL, pick_kind(), idle));
				else
					push_cmd(make_item(OP_ISSUE, CK_MATCH, idle));
			end
		end
		1: begin
			// retire outstanding requests, mostly cleanly
			n = $urandom_range(60, 20);
			for (i = 0; i < n; i++) begin
				if ($urandom_range(4) != 0)
					push_cmd(make_item(OP_CPL, CK_MATCH, idle));
				else
					push_cmd(make_item(pick_op(), pick_kind(), idle));
			end
		end
		2: begin
			// channel reset, resends, then an issue that may find nothing marked
			push_cmd(make_item(OP_RESET, CK_MATCH, idle));
			n = $urandom_range(20, 1);
			for (i = 0; i < n; i++) begin
				if ($urandom_range(3) != 0)
					push_cmd(make_item(OP_ISSUE, CK_MATCH, idle));
				else
					push_cmd(make_item(OP_CPL, pick_kind(), idle));
			end
			push_cmd(make_item(OP_ISSUE, CK_MATCH, idle));
		end
		default: begin
			for (i = 0; i < 20; i++) begin
				op = pick_op();
				push_cmd(make_item(op, pick_kind(), idle));
			end
		end
		endcase
	endtask

	// short directed run at reset register values: each rule and corner at least once
	task automatic add_directed();
		cmd_t e;
		e = make_item(OP_CPL, CK_OUT_RANGE, 0);
		e.rnd_slot = 16'hFFFF;
		push_cmd(e);
		e = make_item(OP_NOP, CK_MATCH, 0);
		e.stamp = '1;
		e.rnd_magic = '1;
		e.rnd_core = '1;
		e.rnd_seq = '1;
		push_cmd(e);
		e = make_item(OP_ISSUE, CK_MATCH, 0);
		e.stamp = '0;
		push_cmd(e);
		e = make_item(OP_ISSUE, CK_MATCH, 0);
		e.stamp = '1;
		push_cmd(e);
		push_cmd(make_item(OP_ISSUE, CK_MATCH, 0));
		push_cmd(make_item(OP_CPL, CK_BAD_MAGIC, 0));
		push_cmd(make_item(OP_CPL, CK_BAD_CORE, 0));
		e = make_item(OP_CPL, CK_OUT_RANGE, 0);
		e.rnd_slot = 16'(SLOT_COUNT);
		push_cmd(e);
		push_cmd(make_item(OP_CPL, CK_WRONG_SEQ, 0));
		e = make_item(OP_CPL, CK_MATCH, 0);
		e.stamp = 64'd5;
		push_cmd(e);
		// hold off until every result is back, then retire another one
		e = make_item(OP_CPL, CK_MATCH, 0);
		e.stamp = '1;
		e.wait_empty = 1'b1;
		push_cmd(e);
		// freed slot with sequence zero is still a mismatch
		e = make_item(OP_CPL, CK_FREE_SLOT, 0);
		e.rnd_seq = '0;
		push_cmd(e);
		push_cmd(make_item(OP_RESET, CK_MATCH, 0));
		push_cmd(make_item(OP_ISSUE, CK_MATCH, 0));
		push_cmd(make_item(OP_ISSUE, CK_MATCH, 0));
		push_cmd(make_item(OP_ISSUE, CK_MATCH, 0));
		push_cmd(make_item(OP_CPL, CK_MATCH, 0));
		push_cmd(make_item(OP_ISSUE, CK_MATCH, 0));
		push_cmd(make_item(OP_RESET, CK_MATCH, 0));
		push_cmd(make_item(OP_CPL, CK_MATCH, 0));
		push_cmd(make_item(OP_ISSUE, CK_MATCH, 0));
		push_cmd(make_item(OP_ISSUE, CK_MATCH, 0));
		push_cmd(make_item(OP_NOP, CK_MATCH, 0));
	endtask

	// ------------------------------------------------------------------
	// driver: command beats and register writes, from the backlog
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			took_item = start && !busy;
			if (took_item)
				due_results.push_back(track_item(operation, now, cpl_magic, cpl_core,
					cpl_slot, cpl_seq));
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_OWN_CORE)
					shadow_core = cfg_data[15:0];
				else if (cfg_index == CFG_MAGIC)
					shadow_magic = cfg_data;
			end
			// the block counts as idle once nothing is due and no command is offered
			if (due_results.size() == 0 && !start)
				quiet_cycles++;
			else
				quiet_cycles = 0;
			holding = (start && !took_item) || (cfg_valid && !cfg_ready);
			if (!holding) begin
				if (cmd_backlog.size() == 0) begin
					start     <= 1'b0;
					cfg_valid <= 1'b0;
				end else if (cmd_backlog[0].is_cfg) begin
					start <= 1'b0;
					// registers change only with nothing in flight
					if (quiet_cycles >= QUIET_NEEDED) begin
						next_cmd = cmd_backlog.pop_front();
						cfg_valid <= 1'b1;
						cfg_index <= next_cmd.cfg_idx;
						cfg_data  <= next_cmd.cfg_val;
					end else begin
						cfg_valid <= 1'b0;
					end
				end else begin
					cfg_valid <= 1'b0;
					if ((cmd_backlog[0].wait_empty && quiet_cycles == 0) ||
						$urandom_range(99) < cmd_backlog[0].idle_pct) begin
						start <= 1'b0;
					end else begin
						next_cmd = cmd_backlog.pop_front();
						shape_completion(next_cmd, shaped_magic, shaped_core, shaped_slot,
							shaped_seq);
						start     <= 1'b1;
						operation <= next_cmd.op;
						now       <= next_cmd.stamp;
						cpl_magic <= shaped_magic;
						cpl_core  <= shaped_core;
						cpl_slot  <= shaped_slot;
						cpl_seq   <= shaped_seq;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: every result beat against the oldest due result
	// ------------------------------------------------------------------
	task automatic flag_error(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s", msg);
	endtask

	task automatic check_field(input string name, input logic [63:0] want_v,
		input logic [63:0] got_v);
		if (got_v !== want_v)
			flag_error($sformatf("%s expected %h got %h", name, want_v, got_v));
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (due_results.size() == 0) begin
					flag_error("result beat with nothing due");
				end else begin
					want = due_results.pop_front();
					check_field("granted", want.granted, granted);
					check_field("is_resend", want.is_resend, is_resend);
					check_field("slot_index", want.slot_index, slot_index);
					check_field("request_seq", want.request_seq, request_seq);
					check_field("status", want.status, status);
					check_field("latency", want.latency, latency);
					check_field("total_latency_out", want.total, total_latency_out);
					check_field("completions_out", want.count, completions_out);
				end
			end
			// watchdog: too long without any beat moving on any channel
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				idle_edges = 0;
			else
				idle_edges++;
			if (idle_edges >= WATCHDOG_LIMIT) begin
				$display("[outstanding_request_tracker] ERROR");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// backlog, reset and end of run
	// ------------------------------------------------------------------
	initial begin
		int idle_plan [PHASES];
		int ph;
		int mark;
		int i;
		idle_plan = '{0, 72, 11, 0};
		for (i = 0; i < SLOT_COUNT; i++) begin
			shadow_seq[i] = '0;
			shadow_ts[i]  = '0;
		end
		shadow_mark    = '0;
		shadow_written = '0;
		shadow_resend  = 1'b0;

		for (ph = 0; ph < PHASES; ph++) begin
			mark = items_queued;
			case (ph)
			0: begin
				// reset register values, directed corners, then a table filled past full
				add_directed();
				mark = items_queued;
				for (i = 0; i < 70; i++)
					push_cmd(make_item(OP_ISSUE, CK_MATCH, idle_plan[ph]));
			end
			1: begin
				// all ones, upper data bits of the core write set as well
				cmd_backlog.push_back(make_cfg(CFG_MAGIC, 32'hFFFF_FFFF));
				cmd_backlog.push_back(make_cfg(CFG_OWN_CORE, 32'hFFFF_FFFF));
			end
			2: begin
				cmd_backlog.push_back(make_cfg(CFG_OWN_CORE, $urandom));
				cmd_backlog.push_back(make_cfg(CFG_MAGIC, $urandom));
			end
			default: begin
				// back to zero, core write with junk in the upper half
				cmd_backlog.push_back(make_cfg(CFG_OWN_CORE, {16'($urandom), 16'h0000}));
				cmd_backlog.push_back(make_cfg(CFG_MAGIC, 32'h0000_0000));
			end
			endcase
			while (items_queued - mark < RANDOM_PER_PHASE)
				add_episode(idle_plan[ph]);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (cmd_backlog.size() != 0 || start || cfg_valid || due_results.size() != 0)
			@(posedge clk);
		// extra edges to catch stray result beats
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("[outstanding_request_tracker] OK");
		else
			$display("[outstanding_request_tracker] ERROR");
		$finish;
	end

endmodule
